// ===== design/ggvi_pkg.sv =====
package ggvi_pkg;

	// field widths of the item and result words
	localparam int IDX_W    = 10;
	localparam int WGT_W    = 33;
	localparam int RWD_W    = 32;
	localparam int CNT_W    = 4;
	localparam int SLOT_W   = 3;
	localparam int COST_W   = 48;
	localparam int STAT_W   = 2;
	localparam int ACTIVE_W = 11;
	localparam int ITER_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// command word node and slot fields, wide enough for up to 65536 nodes
	localparam int NODE_CMD_W = 16;
	localparam int SLOT_CMD_W = 4;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;
	localparam logic [ITER_W-1:0]   ITER_RESET   = 16'd700;

	localparam logic signed [COST_W-1:0] COST_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [COST_W-1:0] COST_MIN = 48'sh8000_0000_0000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER   = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD_NODE = 2'd0,
		OP_LOAD_NB   = 2'd1,
		OP_RUN       = 2'd2,
		OP_QUERY     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_QREAD,
		S_RESP,
		S_CLEAR,
		S_SWEEP,
		S_DRAIN,
		S_INIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic                  accept;
		logic                  resp_load;
		logic                  clear_en;
		logic [NODE_CMD_W-1:0] clear_addr;
		logic                  issue_en;
		logic [NODE_CMD_W-1:0] issue_node;
		logic [SLOT_CMD_W-1:0] issue_slot;
		logic                  issue_first;
		logic                  issue_last;
		logic                  bank;
		logic                  sweep_start;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic changed;
	} stat_t;

	// clamp a 50-bit sum to the signed 48-bit cost range
	function automatic logic [COST_W-1:0] sat48(input logic [COST_W+1:0] v);
		logic [COST_W-1:0] r;
		if (!v[COST_W+1] && v[COST_W:COST_W-1] != 2'b00) begin
			r = COST_MAX;
		end else if (v[COST_W+1] && v[COST_W:COST_W-1] != 2'b11) begin
			r = COST_MIN;
		end else begin
			r = v[COST_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/ggvi_ram.sv =====
module ggvi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/ggvi_dp.sv =====
module ggvi_dp #(
	parameter int NODES         = 1024,
	parameter int MAX_NEIGHBORS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ggvi_pkg::cmd_t                      cmd,
	output ggvi_pkg::stat_t                     stat,
	input  logic [1:0]                          operation,
	input  logic [ggvi_pkg::IDX_W-1:0]          node_index,
	input  logic [ggvi_pkg::WGT_W-1:0]          node_weight,
	input  logic signed [ggvi_pkg::RWD_W-1:0]   node_reward,
	input  logic [ggvi_pkg::CNT_W-1:0]          neighbor_count,
	input  logic [ggvi_pkg::SLOT_W-1:0]         neighbor_slot,
	input  logic [ggvi_pkg::IDX_W-1:0]          neighbor_index,
	output logic [ggvi_pkg::STAT_W-1:0]         status,
	output logic [ggvi_pkg::IDX_W-1:0]          next_hop,
	output logic signed [ggvi_pkg::COST_W-1:0]  path_cost
);
	import ggvi_pkg::*;

	localparam int AW    = $clog2(NODES);
	localparam int SW    = MAX_NEIGHBORS > 1 ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int TBL_D = NODES * (2 ** SW);

	// latched item
	op_t             op_q;
	logic [AW-1:0]   idx_q;
	logic            bad_q;
	logic            bad;

	// memory read data
	logic [WGT_W-1:0]  w_rd;
	logic [RWD_W-1:0]  rew_rd;
	logic [CNT_W-1:0]  cnt_rd;
	logic [IDX_W-1:0]  nb_rd;
	logic [IDX_W-1:0]  hop_rd;
	logic [COST_W-1:0] ca_rd [2];
	logic [COST_W-1:0] cj_rd [2];
	logic [COST_W-1:0] ca_sel;
	logic [COST_W-1:0] cj_sel;

	logic          node_we;
	logic          nb_we;
	logic [AW-1:0] jrd_addr;

	// pipeline
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0]     j_s1, j_s2, j_s3, j_s4;
	logic [SW-1:0]     k_s1, k_s2, k_s3;
	logic              first_s1, first_s2, first_s3, first_s4;
	logic              last_s1, last_s2, last_s3, last_s4;
	logic [IDX_W-1:0]  nb_s2, nb_s3, nb_s4;
	logic [CNT_W-1:0]  cnt_s2, cnt_s3;
	logic [RWD_W-1:0]  rew_s2, rew_s3;
	logic [COST_W-1:0] cj_s2, cj_s3, cj_s4;
	logic [IDX_W-1:0]  hj_s2, hj_s3, hj_s4;
	logic [COST_W-1:0] sum1_s3;
	logic [COST_W-1:0] sum2_s4;
	logic              ok_s4;
	logic [COST_W+1:0] add1, add2;

	// per-node running minimum
	logic signed [COST_W-1:0] best_q;
	logic [IDX_W-1:0]         hop_q;
	logic signed [COST_W-1:0] base_best, new_best;
	logic [IDX_W-1:0]         base_hop, new_hop;
	logic                     take;
	logic                     node_wr;
	logic                     changed_q;

	// store write mux
	logic              cost_we [2];
	logic [AW-1:0]     cost_waddr;
	logic [COST_W-1:0] cost_wdata;
	logic              hop_we;
	logic [AW-1:0]     hop_waddr;
	logic [IDX_W-1:0]  hop_wdata;

	// range checks on the incoming word
	always_comb begin
		case (op_t'(operation))
			OP_LOAD_NODE: bad = (32'(node_index) >= NODES) ||
				(32'(neighbor_count) > MAX_NEIGHBORS);
			OP_LOAD_NB:   bad = (32'(node_index) >= NODES) ||
				(32'(neighbor_index) >= NODES) || (32'(neighbor_slot) >= MAX_NEIGHBORS);
			OP_QUERY:     bad = (32'(node_index) >= NODES);
			default:      bad = 1'b0;
		endcase
	end

	assign node_we = cmd.accept && (op_t'(operation) == OP_LOAD_NODE) && !bad;
	assign nb_we   = cmd.accept && (op_t'(operation) == OP_LOAD_NB) && !bad;

	// latch the accepted word
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op_t'(operation);
			idx_q <= AW'(node_index);
			bad_q <= bad;
		end
	end

	assign jrd_addr = cmd.issue_en ? cmd.issue_node[AW-1:0] : idx_q;

	// node stores
	ggvi_ram #(.WIDTH(WGT_W), .DEPTH(NODES)) u_weight (
		.clk(clk), .we(node_we), .waddr(AW'(node_index)), .wdata(node_weight),
		.raddr(AW'(nb_rd)), .rdata(w_rd)
	);

	ggvi_ram #(.WIDTH(RWD_W), .DEPTH(NODES)) u_reward (
		.clk(clk), .we(node_we), .waddr(AW'(node_index)), .wdata(node_reward),
		.raddr(jrd_addr), .rdata(rew_rd)
	);

	ggvi_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_count (
		.clk(clk), .we(node_we), .waddr(AW'(node_index)), .wdata(neighbor_count),
		.raddr(jrd_addr), .rdata(cnt_rd)
	);

	ggvi_ram #(.WIDTH(IDX_W), .DEPTH(TBL_D)) u_nbtab (
		.clk(clk), .we(nb_we),
		.waddr({AW'(node_index), SW'(neighbor_slot)}),
		.wdata(neighbor_index),
		.raddr({cmd.issue_node[AW-1:0], cmd.issue_slot[SW-1:0]}),
		.rdata(nb_rd)
	);

	ggvi_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_hop (
		.clk(clk), .we(hop_we), .waddr(hop_waddr), .wdata(hop_wdata),
		.raddr(jrd_addr), .rdata(hop_rd)
	);

	// two cost banks, each with a copy for neighbor reads and one for own reads
	for (genvar b = 0; b < 2; b++) begin : g_bank
		ggvi_ram #(.WIDTH(COST_W), .DEPTH(NODES)) u_cost_nb (
			.clk(clk), .we(cost_we[b]), .waddr(cost_waddr), .wdata(cost_wdata),
			.raddr(AW'(nb_rd)), .rdata(ca_rd[b])
		);
		ggvi_ram #(.WIDTH(COST_W), .DEPTH(NODES)) u_cost_own (
			.clk(clk), .we(cost_we[b]), .waddr(cost_waddr), .wdata(cost_wdata),
			.raddr(jrd_addr), .rdata(cj_rd[b])
		);
	end

	assign ca_sel = ca_rd[cmd.bank];
	assign cj_sel = cj_rd[cmd.bank];

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// first sum: neighbor weight plus neighbor cost
	assign add1 = {{(COST_W+2-WGT_W){1'b0}}, w_rd} + {{2{ca_sel[COST_W-1]}}, ca_sel};
	// second sum: plus own reward
	assign add2 = {{2{sum1_s3[COST_W-1]}}, sum1_s3} +
		{{(COST_W+2-RWD_W){rew_s3[RWD_W-1]}}, rew_s3};

	// advance the payload stages
	always_ff @(posedge clk) begin
		j_s1     <= cmd.issue_node[AW-1:0];
		k_s1     <= cmd.issue_slot[SW-1:0];
		first_s1 <= cmd.issue_first;
		last_s1  <= cmd.issue_last;

		j_s2     <= j_s1;
		k_s2     <= k_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		nb_s2    <= nb_rd;
		cnt_s2   <= cnt_rd;
		rew_s2   <= rew_rd;
		cj_s2    <= cj_sel;
		hj_s2    <= hop_rd;

		j_s3     <= j_s2;
		k_s3     <= k_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		nb_s3    <= nb_s2;
		cnt_s3   <= cnt_s2;
		rew_s3   <= rew_s2;
		cj_s3    <= cj_s2;
		hj_s3    <= hj_s2;
		sum1_s3  <= sat48(add1);

		j_s4     <= j_s3;
		first_s4 <= first_s3;
		last_s4  <= last_s3;
		nb_s4    <= nb_s3;
		cj_s4    <= cj_s3;
		hj_s4    <= hj_s3;
		sum2_s4  <= sat48(add2);
		ok_s4    <= (32'(k_s3) < 32'(cnt_s3));
	end

	// pick the strict minimum, lowest slot first
	always_comb begin
		base_best = first_s4 ? COST_MAX : best_q;
		base_hop  = first_s4 ? IDX_W'(j_s4) : hop_q;
		take      = ok_s4 && ($signed(sum2_s4) < base_best);
		new_best  = take ? $signed(sum2_s4) : base_best;
		new_hop   = take ? nb_s4 : base_hop;
		node_wr   = v_s4 && last_s4;
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			best_q <= new_best;
			hop_q  <= new_hop;
		end
	end

	// note any change in this sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b0;
		end else if (cmd.sweep_start) begin
			changed_q <= 1'b0;
		end else if (node_wr && (new_best != $signed(cj_s4) || new_hop != hj_s4)) begin
			changed_q <= 1'b1;
		end
	end

	// store writes: clearing pass or end of a node
	always_comb begin
		cost_we[0] = cmd.clear_en || (node_wr && cmd.bank);
		cost_we[1] = cmd.clear_en || (node_wr && !cmd.bank);
		cost_waddr = cmd.clear_en ? cmd.clear_addr[AW-1:0] : j_s4;
		cost_wdata = cmd.clear_en ? '0 : new_best;
		hop_we     = cmd.clear_en || node_wr;
		hop_waddr  = cmd.clear_en ? cmd.clear_addr[AW-1:0] : j_s4;
		hop_wdata  = cmd.clear_en ? IDX_W'(cmd.clear_addr[AW-1:0]) : new_hop;
	end

	assign stat.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign stat.changed   = changed_q;

	// result word
	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			case (op_q)
				OP_QUERY: begin
					if (bad_q) begin
						status    <= STAT_RANGE;
						next_hop  <= '0;
						path_cost <= '0;
					end else if (cnt_rd == '0) begin
						status    <= STAT_EMPTY;
						next_hop  <= IDX_W'(idx_q);
						path_cost <= COST_MAX;
					end else begin
						status    <= STAT_OK;
						next_hop  <= hop_rd;
						path_cost <= cj_sel;
					end
				end
				default: begin
					status    <= bad_q ? STAT_RANGE : STAT_OK;
					next_hop  <= '0;
					path_cost <= '0;
				end
			endcase
		end
	end

endmodule

// ===== design/ggvi_ctrl.sv =====
module ggvi_ctrl #(
	parameter int NODES         = 1024,
	parameter int MAX_NEIGHBORS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          operation,
	output logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ggvi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ggvi_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ggvi_pkg::cmd_t                      cmd,
	input  ggvi_pkg::stat_t                     stat
);
	import ggvi_pkg::*;

	localparam int AW = $clog2(NODES);
	localparam int SW = MAX_NEIGHBORS > 1 ? $clog2(MAX_NEIGHBORS) : 1;

	state_t              state_q, state_d;
	logic [ACTIVE_W-1:0] active_q;
	logic [ITER_W-1:0]   iter_q;
	logic [ITER_W-1:0]   it_q;
	logic [AW-1:0]       clr_q;
	logic [AW-1:0]       j_q;
	logic [SW-1:0]       k_q;
	logic                bank_q;
	logic                out_valid_q;
	logic [AW:0]         n;
	logic                clr_last;
	logic                j_last;
	logic                k_last;
	logic                go_on;

	// swept node count, capped at the store size
	assign n = (32'(active_q) > NODES) ? (AW+1)'(NODES) : (AW+1)'(active_q);

	assign clr_last = (clr_q == AW'(NODES - 1));
	assign j_last   = ((AW+1)'(j_q) == n - 1'b1);
	assign k_last   = (k_q == SW'(MAX_NEIGHBORS - 1));
	assign go_on    = stat.changed && (it_q != iter_q);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.bank        = bank_q;
		cmd.clear_addr  = NODE_CMD_W'(clr_q);
		cmd.issue_node  = NODE_CMD_W'(j_q);
		cmd.issue_slot  = SLOT_CMD_W'(k_q);
		cmd.issue_first = (k_q == '0);
		cmd.issue_last  = k_last;
		cmd.accept      = in_valid && (state_q == S_IDLE);
		case (state_q)
			S_INIT: begin
				cmd.clear_en = 1'b1;
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					case (op_t'(operation))
						OP_RUN:   state_d = S_CLEAR;
						OP_QUERY: state_d = S_QREAD;
						default:  state_d = S_RESP;
					endcase
				end
			end
			S_QREAD: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					cmd.resp_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (clr_last) begin
					if (n == '0 || iter_q == '0) begin
						state_d = S_RESP;
					end else begin
						cmd.sweep_start = 1'b1;
						state_d         = S_SWEEP;
					end
				end
			end
			S_SWEEP: begin
				cmd.issue_en = 1'b1;
				if (k_last && j_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					if (go_on) begin
						cmd.sweep_start = 1'b1;
						state_d         = S_SWEEP;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// counters, bank, registers and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= ACTIVE_RESET;
			iter_q      <= ITER_RESET;
			it_q        <= '0;
			clr_q       <= '0;
			j_q         <= '0;
			k_q         <= '0;
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_ACTIVE: active_q <= cfg_data[ACTIVE_W-1:0];
					CFG_ITER:   iter_q   <= cfg_data[ITER_W-1:0];
					default:    ;
				endcase
			end

			if (cmd.resp_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + 1'b1;
				end
				S_IDLE: begin
					if (cmd.accept && op_t'(operation) == OP_RUN) begin
						clr_q  <= '0;
						bank_q <= 1'b0;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					j_q   <= '0;
					k_q   <= '0;
					it_q  <= ITER_W'(1);
				end
				S_SWEEP: begin
					if (k_last) begin
						k_q <= '0;
						j_q <= j_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!stat.pipe_busy) begin
						bank_q <= ~bank_q;
						j_q    <= '0;
						k_q    <= '0;
						if (go_on) begin
							it_q <= it_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_clear_vs_issue: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear_en && cmd.issue_en))
		else $error("clearing pass overlaps a sweep");

	a_resp_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an untaken word");

	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue_en |-> ((AW+1)'(j_q) < n))
		else $error("sweep issued past the active nodes");

	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && !stat.pipe_busy) |=> (bank_q != $past(bank_q)))
		else $error("cost bank did not flip at end of sweep");

endmodule

// ===== design/grid_graph_value_iteration.sv =====
// Channel  Direction  Handshake            Word
// in       to block   in_valid / in_stall  operation, node and neighbor fields
// out      from block out_valid / out_stall status, next_hop, path_cost
// cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A load word passes S_RESP, a query word S_QREAD then S_RESP, before the next is accepted.
// A run clears NODES entries, then each sweep streams min(active, NODES)*MAX_NEIGHBORS
// neighbor reads through the memory read ports and drains the pipeline,
// repeated until a sweep changes nothing or the count is done.
// Reset loads the two registers and starts a pass over NODES entries that zeroes costs.
// in_stall is high until the result of the current word is in the output register.
module grid_graph_value_iteration #(
	parameter int NODES         = 1024,
	parameter int MAX_NEIGHBORS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          operation,
	input  logic [ggvi_pkg::IDX_W-1:0]          node_index,
	input  logic [ggvi_pkg::WGT_W-1:0]          node_weight,
	input  logic signed [ggvi_pkg::RWD_W-1:0]   node_reward,
	input  logic [ggvi_pkg::CNT_W-1:0]          neighbor_count,
	input  logic [ggvi_pkg::SLOT_W-1:0]         neighbor_slot,
	input  logic [ggvi_pkg::IDX_W-1:0]          neighbor_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ggvi_pkg::STAT_W-1:0]         status,
	output logic [ggvi_pkg::IDX_W-1:0]          next_hop,
	output logic signed [ggvi_pkg::COST_W-1:0]  path_cost,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ggvi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ggvi_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ggvi_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ggvi_ctrl #(.NODES(NODES), .MAX_NEIGHBORS(MAX_NEIGHBORS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.out_valid(out_valid), .out_stall(out_stall),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .stat(stat)
	);

	ggvi_dp #(.NODES(NODES), .MAX_NEIGHBORS(MAX_NEIGHBORS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .stat(stat),
		.operation(operation), .node_index(node_index), .node_weight(node_weight),
		.node_reward(node_reward), .neighbor_count(neighbor_count),
		.neighbor_slot(neighbor_slot), .neighbor_index(neighbor_index),
		.status(status), .next_hop(next_hop), .path_cost(path_cost)
	);

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ggvi_pkg::*;

	localparam int NODES  = 1024;
	localparam int MAX_NB = 8;
	localparam int NLOAD  = 64;
	localparam longint CMAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint CMIN = -CMAX - 1;

	typedef struct {
		op_t               op;
		logic [9:0]        idx;
		logic [32:0]       wgt;
		logic signed [31:0] rwd;
		logic [3:0]        cnt;
		logic [2:0]        slot;
		logic [9:0]        nb;
	} graph_word_t;

	typedef struct {
		logic [1:0]  status;
		logic [9:0]  hop;
		logic [47:0] cost;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = '0;
	logic [9:0]  node_index = '0;
	logic [32:0] node_weight = '0;
	logic signed [31:0] node_reward = '0;
	logic [3:0]  neighbor_count = '0;
	logic [2:0]  neighbor_slot = '0;
	logic [9:0]  neighbor_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [9:0]  next_hop;
	logic signed [47:0] path_cost;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	grid_graph_value_iteration dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .node_index(node_index), .node_weight(node_weight),
		.node_reward(node_reward), .neighbor_count(neighbor_count),
		.neighbor_slot(neighbor_slot), .neighbor_index(neighbor_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .next_hop(next_hop), .path_cost(path_cost),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// graph model
	logic [32:0]        wgt_mem [NODES];
	logic signed [31:0] rwd_mem [NODES];
	int                 cnt_mem [NODES];
	int                 nb_mem  [NODES][MAX_NB];
	longint             cost_bank [2][NODES];
	int                 hop_mem [NODES];
	int                 cur_bank;
	int                 active_reg = 1024;
	int                 iter_reg = 700;

	// stimulus bookkeeping
	graph_word_t pending_words[$];
	answer_t     expected_answers[$];
	bit          slot_done [NODES][MAX_NB];
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          errors = 0;
	graph_word_t cur_word;

	function automatic longint clamp48(longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	// zero costs, then relax until the sweep count ends or nothing changes
	function automatic void relax_graph();
		int n, prev, nxt, hop, nbi;
		longint best, c;
		bit changed;
		n = (active_reg > NODES) ? NODES : active_reg;
		for (int j = 0; j < NODES; j++) begin
			cost_bank[0][j] = 0;
			cost_bank[1][j] = 0;
			hop_mem[j] = j;
		end
		cur_bank = 0;
		for (int it = 0; it < iter_reg; it++) begin
			prev = cur_bank;
			nxt = prev ^ 1;
			changed = 0;
			for (int j = 0; j < n; j++) begin
				best = CMAX;
				hop = j;
				for (int k = 0; k < cnt_mem[j]; k++) begin
					nbi = nb_mem[j][k];
					c = clamp48(longint'(wgt_mem[nbi]) + cost_bank[prev][nbi]);
					c = clamp48(c + longint'(rwd_mem[j]));
					if (c < best) begin
						best = c;
						hop = nbi;
					end
				end
				if (best != cost_bank[prev][j] || hop != hop_mem[j]) changed = 1;
				cost_bank[nxt][j] = best;
				hop_mem[j] = hop;
			end
			cur_bank = nxt;
			if (!changed) break;
		end
	endfunction

	function automatic answer_t apply_word(graph_word_t w);
		answer_t a;
		a.status = STAT_OK;
		a.hop = '0;
		a.cost = '0;
		case (w.op)
			OP_LOAD_NODE: begin
				if (w.cnt > MAX_NB) a.status = STAT_RANGE;
				else begin
					wgt_mem[w.idx] = w.wgt;
					rwd_mem[w.idx] = w.rwd;
					cnt_mem[w.idx] = w.cnt;
				end
			end
			OP_LOAD_NB: nb_mem[w.idx][w.slot] = w.nb;
			OP_RUN: relax_graph();
			default: begin
				if (cnt_mem[w.idx] == 0) begin
					a.status = STAT_EMPTY;
					a.hop = w.idx;
					a.cost = CMAX[47:0];
				end else begin
					a.hop = 10'(hop_mem[w.idx]);
					a.cost = cost_bank[cur_bank][w.idx][47:0];
				end
			end
		endcase
		return a;
	endfunction

	// drive words from the pending queue, predict at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) expected_answers = {expected_answers, apply_word(cur_word)};
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_word = pending_words.pop_front();
					operation <= cur_word.op;
					node_index <= cur_word.idx;
					node_weight <= cur_word.wgt;
					node_reward <= cur_word.rwd;
					neighbor_count <= cur_word.cnt;
					neighbor_slot <= cur_word.slot;
					neighbor_index <= cur_word.nb;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// stall randomly and check each result word
	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result word status=%0d", status);
				end else begin
					e = expected_answers.pop_front();
					if (status !== e.status || next_hop !== e.hop || path_cost !== e.cost) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp st=%0d hop=%0d cost=%h got st=%0d hop=%0d cost=%h",
								e.status, e.hop, e.cost, status, next_hop, path_cost);
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic logic [32:0] rand_weight();
		case ($urandom_range(3))
			0: return '0;
			1: return 33'($urandom_range(1048576));
			2: return {1'($urandom_range(1)), 32'($urandom)};
			default: return $urandom_range(1) ? 33'h1_FFFF_FFFF : 33'd6553600000;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_reward();
		case ($urandom_range(3))
			0: return 32'($urandom);
			1: return 32'(int'($urandom_range(2000000)) - 1000000);
			2: return 32'($urandom_range(65536));
			default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		endcase
	endfunction

	function automatic int rand_node(int lim);
		return ($urandom_range(4) == 0) ? $urandom_range(NLOAD - 1) : $urandom_range(lim - 1);
	endfunction

	function automatic void add_word(graph_word_t w);
		pending_words = {pending_words, w};
	endfunction

	task automatic queue_nb(int idx, int slot, int nb);
		graph_word_t w;
		w = '{op: OP_LOAD_NB, idx: 10'(idx), wgt: rand_weight(), rwd: rand_reward(),
			cnt: 4'($urandom), slot: 3'(slot), nb: 10'(nb)};
		slot_done[idx][slot] = 1;
		add_word(w);
	endtask

	// load a node and fill any unwritten slot that its count uncovers
	task automatic queue_node(int idx, logic [32:0] wg, logic signed [31:0] rw, int cnt, int lim);
		graph_word_t w;
		w = '{op: OP_LOAD_NODE, idx: 10'(idx), wgt: wg, rwd: rw, cnt: 4'(cnt),
			slot: 3'($urandom), nb: 10'($urandom)};
		add_word(w);
		if (cnt <= MAX_NB)
			for (int s = 0; s < cnt; s++)
				if (!slot_done[idx][s]) queue_nb(idx, s, rand_node(lim));
	endtask

	task automatic queue_simple(op_t op, int idx);
		graph_word_t w;
		w = '{op: op, idx: 10'(idx), wgt: rand_weight(), rwd: rand_reward(),
			cnt: 4'($urandom), slot: 3'($urandom), nb: 10'($urandom)};
		add_word(w);
	endtask

	task automatic write_reg(logic [0:0] which, int value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= 16'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (which == CFG_ACTIVE) active_reg = value & 16'h07FF;
		else iter_reg = value & 16'hFFFF;
	endtask

	// hold until every queued word has been answered and the block settles
	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_regs(int act, int iters);
		drain();
		write_reg(CFG_ACTIVE, act);
		write_reg(CFG_ITER, iters);
	endtask

	initial begin
		int act, lim, pick, idx;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load the low nodes with no neighbors so all later reads are defined
		for (int j = 0; j < NLOAD; j++) queue_node(j, rand_weight(), rand_reward(), 0, 2);
		set_regs(NLOAD, 700);
		queue_simple(OP_RUN, 0);
		queue_simple(OP_QUERY, 0);
		queue_simple(OP_QUERY, NLOAD - 1);

		// bad counts, extreme fields, ties and saturation on a tiny graph
		queue_node(0, 33'h1_FFFF_FFFF, 32'sh8000_0000, 9, 3);
		queue_node(0, 33'h0, 32'sh7FFF_FFFF, 15, 3);
		queue_node(0, 33'h1_FFFF_FFFF, 32'sh8000_0000, 2, 3);
		queue_nb(0, 0, 1);
		queue_nb(0, 1, 2);
		queue_node(1, 33'h0, 32'sh7FFF_FFFF, 1, 3);
		queue_nb(1, 0, 0);
		queue_node(2, 33'd65536, 32'sh0, 8, 3);
		for (int s = 0; s < MAX_NB; s++) queue_nb(2, s, (s == 7) ? NLOAD - 1 : s % 2);
		set_regs(3, 1);
		queue_simple(OP_RUN, 0);
		for (int j = 0; j < 3; j++) queue_simple(OP_QUERY, j);
		set_regs(3, 0);
		queue_simple(OP_RUN, 0);
		queue_simple(OP_QUERY, 2);
		set_regs(0, 65535);
		queue_simple(OP_RUN, 0);
		queue_simple(OP_QUERY, 0);
		set_regs(NLOAD, 1);
		queue_simple(OP_RUN, 0);
		queue_simple(OP_QUERY, 1);
		set_regs(1, 30);
		queue_simple(OP_RUN, 0);
		queue_simple(OP_QUERY, 0);

		// random phases, each under one idling mode
		for (int ph = 0; ph < 4; ph++) begin
			for (int sub = 0; sub < 5; sub++) begin
				if (sub == 4 && ph == 1) set_regs(NLOAD, $urandom_range(1, 2));
				else set_regs($urandom_range(1, 24), $urandom_range(1, 40));
				send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 25 : 0;
				recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 25 : 0;
				act = (active_reg > NODES) ? NODES : active_reg;
				lim = (act < 2) ? 2 : act;
				for (int n = 0; n < 20; n++) begin
					pick = $urandom_range(99);
					idx = rand_node(lim);
					if (pick < 30)
						queue_node(idx, rand_weight(), rand_reward(),
							($urandom_range(9) == 0) ? $urandom_range(9, 15) : $urandom_range(8),
							lim);
					else if (pick < 55) queue_nb(idx, $urandom_range(7), rand_node(lim));
					else if (pick < 63) queue_simple(OP_RUN, 0);
					else queue_simple(OP_QUERY, idx);
				end
				queue_simple(OP_RUN, 0);
				for (int q = 0; q < 4; q++) queue_simple(OP_QUERY, $urandom_range(lim - 1));
			end
		end

		drain();
		if (errors == 0 && expected_answers.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#(64'd60_000_000);
		$display("== FAIL ==");
		$finish;
	end

endmodule
